### rtl/restricted_cubic_spline_basis_defines.svh
// Assertion macros for the restricted cubic spline basis block.
// Used by the port checker; no other dependencies.
`ifndef RESTRICTED_CUBIC_SPLINE_BASIS_DEFINES_SVH
`define RESTRICTED_CUBIC_SPLINE_BASIS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCSB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rcsb same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rcsb next-cycle check failed");

`endif

### rtl/rcsb_pkg.sv
// Shared constants, types and helper functions of the spline basis block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcsb_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 24;
	localparam int CFG_W      = 24;
	localparam int IDX_W      = 3;
	localparam int MAX_KNOTS  = 6;
	localparam int NUM_CELLS  = MAX_KNOTS - 2;
	localparam int D_W        = IN_W + 1;
	localparam int UD_W       = IN_W;
	localparam int SQ_W       = 2 * UD_W;
	localparam int S_W        = SQ_W - FRAC_BITS + 1;
	localparam int PROD_W     = S_W + UD_W;
	localparam int P_W        = PROD_W - FRAC_BITS;
	localparam int LAM_BITS   = 30;
	localparam int LAM_W      = LAM_BITS + 1;
	localparam int P_LO_W     = 32;
	localparam int P_HI_W     = P_W - P_LO_W;
	localparam int LO_W       = P_LO_W + LAM_W;
	localparam int HI_W       = P_HI_W + LAM_W;
	localparam int MM_W       = P_W + 1;
	localparam int VAL_W      = 64;
	localparam int DVD_W      = UD_W + LAM_BITS + 1;
	localparam int CNT_W      = $clog2(DVD_W);
	localparam int OUT_DATA_W = 72;

	localparam logic [IDX_W-1:0] REG_DERIV = 3'd0;
	localparam logic [IDX_W-1:0] REG_KNOTS = 3'd1;
	localparam logic [IDX_W-1:0] REG_KNOT0 = 3'd2;

	// Sample token handed from cell to cell.
	typedef struct packed {
		logic             valid;
		logic             deriv;
		logic [IDX_W-1:0] cols;
		logic [IN_W-1:0]  x;
		logic [P_W-1:0]   pmin;
		logic [P_W-1:0]   pmax;
	} token_t;

	// One finished basis column from a cell.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [VAL_W-1:0] value;
	} result_t;

	// Lambda write broadcast from the division unit to the cells.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic [LAM_W-1:0] lam;
	} lam_wr_t;

	// Number of basis columns for a knot count, clamped to the legal range.
	function automatic logic [IDX_W-1:0] eff_cols(input logic [IDX_W-1:0] n);
		logic [IDX_W-1:0] c;
		if (n < IDX_W'(2))
			c = IDX_W'(1);
		else if (n > IDX_W'(MAX_KNOTS))
			c = IDX_W'(MAX_KNOTS - 1);
		else
			c = n - IDX_W'(1);
		return c;
	endfunction

	// round(p * lam / 2^LAM_BITS) from the split partial products.
	function automatic logic [MM_W-1:0] mm_round(input logic [HI_W-1:0] hi,
	                                            input logic [LO_W-1:0] lo);
		logic [LO_W:0] t;
		t = (LO_W+1)'(lo) + ((LO_W+1)'(1) << (LAM_BITS - 1));
		return (MM_W'(hi) << (P_LO_W - LAM_BITS)) + MM_W'(t >> LAM_BITS);
	endfunction

endpackage

### rtl/restricted_cubic_spline_basis.sv
// Top level of the restricted cubic spline basis row generator.
// Depends on rcsb_pkg, rcsb_cube, rcsb_lam and rcsb_cell.
`timescale 1ns / 1ps

// Each accepted sample (signed Q8.16) yields one basis row over the configured
// knots, one column per output transfer: column 0 is the linear term (x, or
// 1.0 in derivative mode), columns 1..knots-2 are the interior-knot terms in
// signed Q48.16, and tlast marks the final column of the row. A row holds
// knots_in_use-1 columns, clamped to one to five: the row of interior-knot cells
// shares a single output register, which carries one column per cycle unless
// the output stalls, so the input is held off after each transfer while the
// rest of the row is issued. After reset and after every register write the
// lambda weights are recomputed by a bit-serial divider, one interior knot
// after another; s_axis_tready stays low for that time. Output stalls freeze
// the whole chain.
module restricted_cubic_spline_basis (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [rcsb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [rcsb_pkg::CFG_W-1:0]        cfg_data,
	// sample stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rcsb_pkg::IN_W-1:0]         s_axis_tdata,  // [23:0] sample
	// basis column stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [rcsb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [2:0] basis_index,
	                                                         // [66:3] basis_value
	output logic                              m_axis_tlast   // last_of_row
);
	import rcsb_pkg::*;

	localparam int LIN_DLY = 4;

	// configuration registers
	logic             deriv_q;
	logic [IDX_W-1:0] knots_in_use_q;
	logic [IN_W-1:0]  knot_q [MAX_KNOTS];
	logic [IDX_W-1:0] cols;

	// control
	logic             en, accept, busy;
	logic [IDX_W-1:0] gap_q;
	lam_wr_t          lam_wr;
	logic [IN_W-1:0]  kmax;

	// front stages
	token_t           a0_q, b1_q, b2_q, b3_q;
	logic [P_W-1:0]   pmin, pmax;
	token_t           tok [NUM_CELLS+1];
	result_t          res [NUM_CELLS];
	result_t          lin_q [LIN_DLY];

	// output register
	logic             out_vld_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_last_q;
	logic             nxt_vld, nxt_last;
	logic [IDX_W-1:0] nxt_idx;
	logic [VAL_W-1:0] nxt_val;

	assign cols = eff_cols(knots_in_use_q);

	// Hold everything while a finished column waits downstream.
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en && !busy && (gap_q == '0);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deriv_q        <= 1'b0;
			knots_in_use_q <= IDX_W'(MAX_KNOTS);
			for (int i = 0; i < MAX_KNOTS; i++)
				knot_q[i] <= IN_W'(i) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DERIV: deriv_q <= cfg_data[0];
				REG_KNOTS: knots_in_use_q <= cfg_data[IDX_W-1:0];
				default:   knot_q[cfg_index - REG_KNOT0] <= cfg_data[IN_W-1:0];
			endcase
		end
	end

	rcsb_lam u_lam (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.knots  (knot_q),
		.cols   (cols),
		.lam_wr (lam_wr),
		.kmax   (kmax),
		.busy   (busy)
	);

	// Space samples so each row owns consecutive output slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_q <= '0;
		else if (en) begin
			if (accept)
				gap_q <= cols - IDX_W'(1);
			else if (gap_q != '0)
				gap_q <= gap_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			b3_q <= '0;
		end else if (en) begin
			a0_q.valid <= accept;
			a0_q.deriv <= deriv_q;
			a0_q.cols  <= cols;
			a0_q.x     <= s_axis_tdata;
			a0_q.pmin  <= '0;
			a0_q.pmax  <= '0;
			b1_q       <= a0_q;
			b2_q       <= b1_q;
			b3_q       <= b2_q;
		end
	end

	// boundary terms, shared by all cells
	rcsb_cube u_cube_min (
		.clk   (clk),
		.en    (en),
		.x     (a0_q.x),
		.k     (knot_q[0]),
		.deriv (a0_q.deriv),
		.p     (pmin)
	);

	rcsb_cube u_cube_max (
		.clk   (clk),
		.en    (en),
		.x     (a0_q.x),
		.k     (kmax),
		.deriv (a0_q.deriv),
		.p     (pmax)
	);

	always_comb begin
		tok[0]      = b3_q;
		tok[0].pmin = pmin;
		tok[0].pmax = pmax;
	end

	for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
		rcsb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.col    (IDX_W'(j + 1)),
			.knot   (knot_q[j+1]),
			.lam_wr (lam_wr),
			.tok_i  (tok[j]),
			.tok_o  (tok[j+1]),
			.res_o  (res[j])
		);
	end

	// Delay the linear column so it lands one slot ahead of cell 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIN_DLY; i++)
				lin_q[i] <= '0;
		end else if (en) begin
			lin_q[0].valid <= b3_q.valid;
			lin_q[0].last  <= (b3_q.cols == IDX_W'(1));
			lin_q[0].value <= b3_q.deriv ? (VAL_W'(1) << FRAC_BITS)
			                             : {{(VAL_W-IN_W){b3_q.x[IN_W-1]}}, b3_q.x};
			for (int i = 1; i < LIN_DLY; i++)
				lin_q[i] <= lin_q[i-1];
		end
	end

	// At most one source is valid in any slot.
	always_comb begin
		nxt_vld  = lin_q[LIN_DLY-1].valid;
		nxt_last = lin_q[LIN_DLY-1].last;
		nxt_val  = lin_q[LIN_DLY-1].value;
		nxt_idx  = '0;
		for (int j = 0; j < NUM_CELLS; j++) begin
			if (res[j].valid) begin
				nxt_vld  = 1'b1;
				nxt_last = res[j].last;
				nxt_val  = res[j].value;
				nxt_idx  = IDX_W'(j + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= nxt_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_idx_q  <= nxt_idx;
			out_val_q  <= nxt_val;
			out_last_q <= nxt_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OUT_DATA_W - VAL_W - IDX_W)'(0), out_val_q, out_idx_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### rtl/rcsb_cube.sv
// Positive-part cube (or three times the positive-part square) of x - k.
// Three register stages; depends on rcsb_pkg.
`timescale 1ns / 1ps

module rcsb_cube (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rcsb_pkg::IN_W-1:0]  x,
	input  logic [rcsb_pkg::IN_W-1:0]  k,
	input  logic                       deriv,
	output logic [rcsb_pkg::P_W-1:0]   p
);
	import rcsb_pkg::*;

	localparam logic [SQ_W-1:0]   HALF_SQ   = SQ_W'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W-1:0] HALF_PROD = PROD_W'(1) << (FRAC_BITS - 1);

	logic [D_W-1:0]    d;
	logic              pos;
	logic              pos_s1, deriv_s1, pos_s2, deriv_s2;
	logic [UD_W-1:0]   ud_s1;
	logic [SQ_W-1:0]   sq_s1;
	logic [SQ_W-1:0]   sq_rnd;
	logic [S_W-1:0]    s;
	logic [S_W-1:0]    s_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0] prod_rnd;

	assign d   = {x[IN_W-1], x} - {k[IN_W-1], k};
	assign pos = !d[D_W-1] && (d != '0);

	assign sq_rnd   = sq_s1 + HALF_SQ;
	assign s        = S_W'(sq_rnd >> FRAC_BITS);
	assign prod_rnd = prod_s2 + HALF_PROD;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1   <= pos;
			deriv_s1 <= deriv;
			ud_s1    <= d[UD_W-1:0];
			sq_s1    <= SQ_W'(d[UD_W-1:0]) * SQ_W'(d[UD_W-1:0]);
			pos_s2   <= pos_s1;
			deriv_s2 <= deriv_s1;
			s_s2     <= s;
			prod_s2  <= PROD_W'(s) * PROD_W'(ud_s1);
			if (!pos_s2)
				p <= '0;
			else if (deriv_s2)
				p <= P_W'(s_s2) * P_W'(3);
			else
				p <= P_W'(prod_rnd >> FRAC_BITS);
		end
	end

endmodule

### rtl/rcsb_lam.sv
// Lambda unit: recomputes the interior-knot weights after reset and after
// each register write with a restoring divider, one quotient bit per cycle.
// Depends on rcsb_pkg.
`timescale 1ns / 1ps

module rcsb_lam (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rcsb_pkg::IN_W-1:0] knots [rcsb_pkg::MAX_KNOTS],
	input  logic [rcsb_pkg::IDX_W-1:0] cols,
	output rcsb_pkg::lam_wr_t         lam_wr,
	output logic [rcsb_pkg::IN_W-1:0] kmax,
	output logic                      busy
);
	import rcsb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_LOAD  = 4'b0100,
		ST_DIV   = 4'b1000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] kidx_q;
	logic [IN_W-1:0]  kmax_q;
	logic [IN_W-1:0]  ksh_q [NUM_CELLS];
	logic [UD_W-1:0]  den_q;
	logic             den_pos_q;
	logic [DVD_W-1:0] dvd_q;
	logic [UD_W-1:0]  rem_q;
	logic [LAM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;

	logic [D_W-1:0]   den_full, num_full;
	logic [UD_W-1:0]  num_c;
	logic [UD_W:0]    r;
	logic [UD_W:0]    r_sub;
	logic             ge, last_step, done_knot;

	assign den_full  = {knots[cols][IN_W-1], knots[cols]} - {knots[0][IN_W-1], knots[0]};
	assign num_full  = {kmax_q[IN_W-1], kmax_q} - {ksh_q[0][IN_W-1], ksh_q[0]};
	assign r         = {rem_q, dvd_q[DVD_W-1]};
	assign r_sub     = r - {1'b0, den_q};
	assign ge        = !r_sub[UD_W];
	assign last_step = (cnt_q == CNT_W'(DVD_W - 1));
	assign done_knot = (state_q == ST_LOAD && !den_pos_q) || (state_q == ST_DIV && last_step);

	always_comb begin
		if (num_full[D_W-1])
			num_c = '0;
		else if (num_full[UD_W-1:0] > den_q)
			num_c = den_q;
		else
			num_c = num_full[UD_W-1:0];
	end

	assign lam_wr.we  = done_knot;
	assign lam_wr.idx = kidx_q;
	assign lam_wr.lam = (state_q == ST_DIV) ? {quo_q[LAM_W-2:0], ge} : '0;
	assign kmax       = kmax_q;
	assign busy       = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			kidx_q  <= IDX_W'(1);
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_START;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_START: begin
					kidx_q  <= IDX_W'(1);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q <= '0;
					if (den_pos_q)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				default: state_q <= ST_START;
			endcase
			if (done_knot) begin
				if (kidx_q == IDX_W'(NUM_CELLS))
					state_q <= ST_IDLE;
				else begin
					kidx_q  <= kidx_q + IDX_W'(1);
					state_q <= ST_LOAD;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			// the span is the same for every knot; latch it once
			kmax_q    <= knots[cols];
			den_q     <= den_full[UD_W-1:0];
			den_pos_q <= !den_full[D_W-1] && (den_full != '0);
			for (int i = 0; i < NUM_CELLS; i++)
				ksh_q[i] <= knots[i+1];
		end
		if (state_q == ST_LOAD && den_pos_q) begin
			dvd_q <= (DVD_W'(num_c) << LAM_BITS) + DVD_W'(den_q >> 1);
			rem_q <= '0;
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? r_sub[UD_W-1:0] : r[UD_W-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[LAM_W-2:0], ge};
		end
		if (done_knot) begin
			for (int i = 0; i < NUM_CELLS - 1; i++)
				ksh_q[i] <= ksh_q[i+1];
		end
	end

endmodule

### rtl/rcsb_cell.sv
// One interior-knot cell: holds its lambda, passes the sample token on each
// cycle unless the output stalls, and produces its basis column through the c1 to c4 registers.
// Depends on rcsb_pkg and rcsb_cube.
`timescale 1ns / 1ps

module rcsb_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [rcsb_pkg::IDX_W-1:0] col,
	input  logic [rcsb_pkg::IN_W-1:0]  knot,
	input  rcsb_pkg::lam_wr_t          lam_wr,
	input  rcsb_pkg::token_t           tok_i,
	output rcsb_pkg::token_t           tok_o,
	output rcsb_pkg::result_t          res_o
);
	import rcsb_pkg::*;

	token_t            in_q;
	logic [LAM_W-1:0]  lam_q, lamc_q;
	logic              vld_c1, vld_c2, vld_c3, vld_c4;
	logic              last_c1, last_c2, last_c3, last_c4;
	logic [LO_W-1:0]   lo_min_c1, lo_max_c2;
	logic [HI_W-1:0]   hi_min_c1, hi_max_c2;
	logic [P_W-1:0]    pmax_c1;
	logic [MM_W-1:0]   mmin_c2, mmin_c3, mmax_c3;
	logic [P_W-1:0]    pk;
	logic [VAL_W-1:0]  val_c4;

	rcsb_cube u_cube (
		.clk   (clk),
		.en    (en),
		.x     (in_q.x),
		.k     (knot),
		.deriv (in_q.deriv),
		.p     (pk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q   <= '0;
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
			vld_c3 <= 1'b0;
			vld_c4 <= 1'b0;
		end else if (en) begin
			in_q   <= tok_i;
			vld_c1 <= in_q.valid && (col < in_q.cols);
			vld_c2 <= vld_c1;
			vld_c3 <= vld_c2;
			vld_c4 <= vld_c3;
		end
	end

	always_ff @(posedge clk) begin
		if (lam_wr.we && lam_wr.idx == col) begin
			lam_q  <= lam_wr.lam;
			lamc_q <= (LAM_W'(1) << LAM_BITS) - lam_wr.lam;
		end
		if (en) begin
			last_c1   <= (col == in_q.cols - IDX_W'(1));
			lo_min_c1 <= LO_W'(in_q.pmin[P_LO_W-1:0]) * LO_W'(lam_q);
			hi_min_c1 <= HI_W'(in_q.pmin[P_W-1:P_LO_W]) * HI_W'(lam_q);
			pmax_c1   <= in_q.pmax;
			last_c2   <= last_c1;
			mmin_c2   <= mm_round(hi_min_c1, lo_min_c1);
			lo_max_c2 <= LO_W'(pmax_c1[P_LO_W-1:0]) * LO_W'(lamc_q);
			hi_max_c2 <= HI_W'(pmax_c1[P_W-1:P_LO_W]) * HI_W'(lamc_q);
			last_c3   <= last_c2;
			mmin_c3   <= mmin_c2;
			mmax_c3   <= mm_round(hi_max_c2, lo_max_c2);
			last_c4   <= last_c3;
			val_c4    <= VAL_W'(pk) - VAL_W'(mmin_c3) - VAL_W'(mmax_c3);
		end
	end

	assign tok_o       = in_q;
	assign res_o.valid = vld_c4;
	assign res_o.last  = last_c4;
	assign res_o.value = val_c4;

endmodule

### rtl/rcsb_checker.sv
// Port-level checker for the spline basis block, bound to the top level.
// Depends on rcsb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "restricted_cubic_spline_basis_defines.svh"

module rcsb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rcsb_pkg::IDX_W-1:0]      cfg_index,
	input  logic [rcsb_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [rcsb_pkg::IN_W-1:0]       s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [rcsb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast
);
	import rcsb_pkg::*;

	// stalled column holds
	`RCSB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	// column index stays within the basis column range
	`RCSB_ASSERT_SAME(a_idx_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[IDX_W-1:0] <= IDX_W'(MAX_KNOTS - 2))
	// a register write starts the lambda recompute, which holds off samples
	`RCSB_ASSERT_NEXT(a_cfg_blocks, clk, arst_n, cfg_we, !s_axis_tready)

endmodule

bind restricted_cubic_spline_basis rcsb_checker u_rcsb_checker (.*);

### test/rcsb_row_checker.sv
// Checker for the spline basis block: predicts every basis column from the
// accepted samples and compares the master stream. Depends on rcsb_pkg.
`timescale 1ns / 1ps

module rcsb_row_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rcsb_pkg::IDX_W-1:0]         cfg_index,
	input  logic [rcsb_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [rcsb_pkg::IN_W-1:0]          s_axis_tdata,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [rcsb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               m_axis_tlast,
	output int                                 fail_count,
	output int                                 pending_columns
);
	import rcsb_pkg::*;

	typedef struct {
		logic [2:0]  idx;
		logic [63:0] value;
		logic        last;
	} column_t;

	column_t     column_q[$];
	logic        deriv_r;
	logic [2:0]  knots_r;
	logic signed [23:0] knot_r[6];

	function automatic logic [127:0] pos_power(input logic signed [63:0] d, input logic dv);
		logic [127:0] ud, s;
		if (d <= 0)
			return 0;
		ud = 128'(d);
		s = (ud * ud + 128'd32768) >> 16;
		if (dv)
			return 3 * s;
		return (s * ud + 128'd32768) >> 16;
	endfunction

	function automatic logic [127:0] weigh(input logic [127:0] p, input logic [127:0] lam);
		return (p * lam + (128'd1 << 29)) >> 30;
	endfunction

	task automatic predict_row(input logic signed [23:0] x);
		int n, cols;
		logic signed [63:0] kmin, kmax, den, num;
		logic [127:0] pmin, pmax, pk, lam;
		logic [63:0] val;
		column_t c;
		n = knots_r;
		if (n < 2) n = 2;
		if (n > 6) n = 6;
		cols = n - 1;
		c.idx = 0;
		c.value = deriv_r ? 64'd65536 : 64'(x);
		c.last = (cols == 1);
		column_q.push_back(c);
		kmin = knot_r[0];
		kmax = knot_r[n-1];
		den = kmax - kmin;
		pmin = pos_power(64'(x) - kmin, deriv_r);
		pmax = pos_power(64'(x) - kmax, deriv_r);
		for (int j = 1; j < cols; j++) begin
			lam = 0;
			pk = pos_power(64'(x) - 64'(knot_r[j]), deriv_r);
			if (den > 0) begin
				num = kmax - 64'(knot_r[j]);
				if (num < 0) num = 0;
				if (num > den) num = den;
				lam = ((128'(num) << 30) + 128'(den >> 1)) / 128'(den);
			end
			val = 64'(pk - weigh(pmin, lam) - weigh(pmax, (128'd1 << 30) - lam));
			c.idx = 3'(j);
			c.value = val;
			c.last = (j == cols - 1);
			column_q.push_back(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		column_t e;
		int errs;
		if (!arst_n) begin
			deriv_r <= 1'b0;
			knots_r <= 3'd6;
			for (int i = 0; i < 6; i++)
				knot_r[i] <= 24'(i * 65536);
			column_q.delete();
			fail_count <= 0;
			pending_columns <= 0;
		end else begin
			errs = 0;
			// retire the output transfer before predicting a new row
			if (m_axis_tvalid && m_axis_tready) begin
				if (column_q.size() == 0) begin
					$error("unexpected column idx=%0d", m_axis_tdata[2:0]);
					errs++;
				end else begin
					e = column_q.pop_front();
					if (m_axis_tdata[2:0] !== e.idx) begin
						$error("basis_index expected %0d actual %0d", e.idx, m_axis_tdata[2:0]);
						errs++;
					end
					if (m_axis_tdata[66:3] !== e.value) begin
						$error("basis_value expected %0d actual %0d", $signed(e.value),
							$signed(m_axis_tdata[66:3]));
						errs++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last_of_row expected %0d actual %0d", e.last, m_axis_tlast);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_row(s_axis_tdata);
			if (cfg_we) begin
				if (cfg_index == REG_DERIV)
					deriv_r <= cfg_data[0];
				else if (cfg_index == REG_KNOTS)
					knots_r <= cfg_data[2:0];
				else
					knot_r[cfg_index - REG_KNOT0] <= cfg_data;
			end
			fail_count <= fail_count + errs;
			pending_columns <= column_q.size();
		end
	end
endmodule

### test/tb_restricted_cubic_spline_basis.sv
// Top of the spline basis testbench: clock, reset, configuration phases,
// sample stimulus and verdict. Depends on rcsb_pkg, the block and rcsb_row_checker.
`timescale 1ns / 1ps

module tb_restricted_cubic_spline_basis;
	import rcsb_pkg::*;

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   cfg_we = 0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_axis_tvalid = 0;
	logic                   s_axis_tready;
	logic [IN_W-1:0]        s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   m_axis_tlast;
	int                     fail_count;
	int                     pending_columns;
	// when set, neither side idles
	logic                   steady = 0;

	localparam logic [IDX_W-1:0] REG_KNOT_LAST = 3'd7;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	restricted_cubic_spline_basis dut (.*);

	rcsb_row_checker checker_i (.*);

	// receiver: drop ready at random with probability 0.19 unless in a steady stretch
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 19);

	// drop the sample stream and wait until every expected column has come
	task automatic wait_empty;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending_columns != 0)
			@(posedge clk);
	endtask

	// write only while nothing is in flight
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_empty();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// hold one sample until it transfers, with a random gap ahead of it unless in a steady stretch
	task automatic send_sample(input logic [IN_W-1:0] x);
		while (!steady && $urandom_range(99) < 19) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= x;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// wait for every expected column, then let the block settle
	task automatic drain;
		wait_empty();
		repeat (20) @(posedge clk);
	endtask

	task automatic load_knots(input int n, input logic deriv, input int base, input int step);
		write_reg(REG_DERIV, CFG_W'(deriv));
		write_reg(REG_KNOTS, CFG_W'(n));
		for (int i = 0; i < 6; i++)
			write_reg(REG_KNOT0 + IDX_W'(i), CFG_W'(base + i * step));
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				send_sample(IN_W'($urandom));
			else
				send_sample(IN_W'($signed(24'($urandom_range(0, 20'hFFFFF))) - 24'sh80000));
		end
	endtask

	initial begin
		int ext[6];
		ext = '{-8388608, -65536, 0, 1, 65536, 8388607};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset knots, basis mode: field extremes and knot points
		foreach (ext[i]) send_sample(IN_W'(ext[i]));
		send_sample(24'h7FFFFF);
		send_sample(24'd131072);
		send_sample(24'd327680);
		drain();

		// derivative mode, extreme boundary knots
		write_reg(REG_DERIV, 1);
		write_reg(REG_KNOT0, 24'h800000);
		write_reg(REG_KNOT_LAST, 24'h7FFFFF);
		for (int i = 0; i < 4; i++) send_sample(IN_W'(ext[i+2]));
		drain();

		// two knots: linear column only; equal boundaries
		load_knots(2, 0, 0, 0);
		send_sample(24'h123456);
		send_sample(24'h800000);
		// out-of-range knot counts
		write_reg(REG_KNOTS, 0);
		send_sample(24'h000100);
		write_reg(REG_KNOTS, 7);
		send_sample(24'h7FFFFF);
		drain();

		// reversed boundaries and interior knots outside them
		load_knots(6, 1, 65536 * 4, -65536);
		send_sample(24'd262144);
		send_sample(24'h7FFFFF);
		write_reg(REG_KNOT0 + 3'd2, 24'h7FFFFF);
		write_reg(REG_KNOT0 + 3'd3, 24'h800000);
		send_sample(24'h200000);
		drain();

		// random phases across several settings
		steady = 1;
		load_knots(6, 0, -65536 * 5, 65536 * 2);
		random_phase(20);
		steady = 0;
		drain();
		load_knots(4, 1, -65536 * 64, 65536 * 40);
		random_phase(25);
		drain();
		load_knots(3, 0, -8388608, 3355443);
		random_phase(20);
		drain();
		load_knots(5, 0, $urandom_range(0, 65536) - 65536 * 2, 65536 + $urandom_range(99999));
		random_phase(35);
		drain();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
